@@ hw/rtl/scan_report_fifo_defines.svh @@
// Assertion macros for the scan report FIFO checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using scope.
`ifndef SCAN_REPORT_FIFO_DEFINES_SVH
`define SCAN_REPORT_FIFO_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/srf_pkg.sv @@
// Shared types, constants and helper functions of the scan report FIFO.
// No dependencies; used by every module of the block.
package srf_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int PAYLOAD_LIMIT  = 31;
    localparam int PAY_WORDS      = 4;
    localparam int WORD_W         = 64;
    localparam int MAC_W          = 48;
    localparam int RSSI_W         = 8;
    localparam int LEN_IN_W       = 8;
    localparam int LEN_W          = 5;
    localparam int DROP_W         = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    // One stored report as it sits in a memory entry.
    typedef struct packed {
        logic [MAC_W-1:0]                  mac;
        logic [RSSI_W-1:0]                 rssi;
        logic [LEN_W-1:0]                  len;
        logic [PAY_WORDS-1:0][WORD_W-1:0]  payload;
    } t_slot;

    // Bookkeeping events raised by the datapath for one accepted item.
    typedef struct packed {
        logic    push_ok;
        logic    pop_ok;
        logic    drop;
        logic    err_set;
        t_status err_kind;
    } t_evt;

    typedef struct packed {
        logic full;
        logic empty;
    } t_flags;

    // Keeps the bytes of payload word w that lie below len.
    function automatic logic [WORD_W-1:0] word_mask(input logic [LEN_W-1:0] len,
                                                    input logic [1:0] w);
        logic [WORD_W-1:0] m;
        logic [LEN_W:0]    pos;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            pos = {1'b0, w, 3'(b)};
            if (pos < {1'b0, len}) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

@@ hw/rtl/srf_ram.sv @@
// Report storage: one write port and one registered read port.
// Depends on srf_pkg for the slot type.
module srf_ram #(
    parameter int DEPTH  = srf_pkg::FIFO_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  srf_pkg::t_slot      i_wr_data,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output srf_pkg::t_slot      o_rd_data
);

    srf_pkg::t_slot r_mem [DEPTH];
    srf_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/srf_stat.sv @@
// Ring pointers, fill count, drop counter, high-water mark and sticky error.
// Depends on srf_pkg for the event and flag structs.
module srf_stat #(
    parameter int FIFO_DEPTH = srf_pkg::FIFO_DEPTH_DEF,
    parameter int IDX_W      = $clog2(FIFO_DEPTH),
    parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srf_pkg::t_evt               i_evt,
    output logic [IDX_W-1:0]            o_wr_idx,
    output logic [IDX_W-1:0]            o_rd_idx,
    output logic [CNT_W-1:0]            o_count,
    output logic [srf_pkg::DROP_W-1:0]  o_drop,
    output logic [CNT_W-1:0]            o_peak,
    output srf_pkg::t_status            o_err,
    output srf_pkg::t_flags             o_flags
);

    logic [IDX_W-1:0]           r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]           r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]           r_count,  n_count;
    logic [srf_pkg::DROP_W-1:0] r_drop,   n_drop;
    logic [CNT_W-1:0]           r_peak,   n_peak;
    srf_pkg::t_status           r_err,    n_err;

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        n_drop   = r_drop;
        n_peak   = r_peak;
        n_err    = r_err;
        if (i_evt.push_ok) begin
            n_wr_idx = (r_wr_idx == IDX_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
            n_count  = r_count + 1'b1;
        end
        if (i_evt.pop_ok) begin
            n_rd_idx = (r_rd_idx == IDX_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
            n_count  = r_count - 1'b1;
            // The peak is sampled before the count drops.
            if (r_count > r_peak) begin
                n_peak = r_count;
            end
        end
        if (i_evt.drop && (r_drop != '1)) begin
            n_drop = r_drop + 1'b1;
        end
        if (i_evt.err_set) begin
            n_err = i_evt.err_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
            r_drop   <= '0;
            r_peak   <= '0;
            r_err    <= srf_pkg::ST_OK;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_peak   <= n_peak;
            r_err    <= n_err;
        end
    end

    assign o_wr_idx      = r_wr_idx;
    assign o_rd_idx      = r_rd_idx;
    assign o_count       = r_count;
    assign o_drop        = r_drop;
    assign o_peak        = r_peak;
    assign o_err         = r_err;
    assign o_flags.full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_flags.empty = (r_count == '0);

endmodule

@@ hw/rtl/scan_report_fifo.sv @@
// Scan report FIFO: one push or pop per cycle unless stalled; the result is valid the cycle after acceptance.
// Throughput is one item per cycle while no held result (o_out_valid with i_out_stall) stalls the input.
// A pop presents its address at acceptance and the read data register feeds the result fields.
// Synchronous active-low reset empties the FIFO and clears drop count, high-water mark and error.
// Memory contents are not cleared; only entries written by a push are ever read.
// Depends on srf_pkg, srf_ram and srf_stat.
module scan_report_fifo #(
    parameter int FIFO_DEPTH = srf_pkg::FIFO_DEPTH_DEF,
    localparam int IDX_W     = $clog2(FIFO_DEPTH),
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic [srf_pkg::MAC_W-1:0]           i_mac,
    input  logic signed [srf_pkg::RSSI_W-1:0]   i_rssi,
    input  logic [srf_pkg::LEN_IN_W-1:0]        i_payload_len,
    input  logic [srf_pkg::WORD_W-1:0]          i_payload_0,
    input  logic [srf_pkg::WORD_W-1:0]          i_payload_1,
    input  logic [srf_pkg::WORD_W-1:0]          i_payload_2,
    input  logic [srf_pkg::WORD_W-1:0]          i_payload_3,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic [1:0]                          o_last_error,
    output logic [srf_pkg::MAC_W-1:0]           o_out_mac,
    output logic signed [srf_pkg::RSSI_W-1:0]   o_out_rssi,
    output logic [srf_pkg::LEN_W-1:0]           o_out_len,
    output logic [srf_pkg::WORD_W-1:0]          o_out_payload_0,
    output logic [srf_pkg::WORD_W-1:0]          o_out_payload_1,
    output logic [srf_pkg::WORD_W-1:0]          o_out_payload_2,
    output logic [srf_pkg::WORD_W-1:0]          o_out_payload_3,
    output logic [CNT_W-1:0]                    o_fill_count,
    output logic [srf_pkg::DROP_W-1:0]          o_drop_count,
    output logic [CNT_W-1:0]                    o_high_water
);

    logic                       w_accept;
    logic                       w_len_bad;
    logic [srf_pkg::LEN_W-1:0]  w_len;
    srf_pkg::t_evt              w_evt;
    srf_pkg::t_flags            w_flags;
    srf_pkg::t_slot             w_wr_slot;
    srf_pkg::t_slot             w_rd_slot;
    srf_pkg::t_status           w_err;
    logic [IDX_W-1:0]           w_wr_idx;
    logic [IDX_W-1:0]           w_rd_idx;
    logic [srf_pkg::PAY_WORDS-1:0][srf_pkg::WORD_W-1:0] w_pay_in;

    logic                       r_out_valid, n_out_valid;
    srf_pkg::t_status           r_status,    n_status;
    logic                       r_pop_ok;

    assign o_in_stall = !i_rst_n || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_len_bad  = i_payload_len > srf_pkg::LEN_IN_W'(srf_pkg::PAYLOAD_LIMIT);
    assign w_len      = i_payload_len[srf_pkg::LEN_W-1:0];

    assign w_pay_in = {i_payload_3, i_payload_2, i_payload_1, i_payload_0};

    // Classify the item and raise bookkeeping events.
    always_comb begin
        w_evt    = '0;
        n_status = srf_pkg::ST_OK;
        if (w_accept) begin
            if (i_operation == srf_pkg::OP_POP) begin
                if (w_flags.empty) begin
                    n_status       = srf_pkg::ST_EMPTY;
                    w_evt.err_set  = 1'b1;
                    w_evt.err_kind = srf_pkg::ST_EMPTY;
                end else begin
                    w_evt.pop_ok = 1'b1;
                end
            end else begin
                // A full FIFO takes precedence over an oversized payload.
                if (w_flags.full) begin
                    n_status       = srf_pkg::ST_FULL;
                    w_evt.drop     = 1'b1;
                    w_evt.err_set  = 1'b1;
                    w_evt.err_kind = srf_pkg::ST_FULL;
                end else if (w_len_bad) begin
                    n_status       = srf_pkg::ST_TOO_LONG;
                    w_evt.drop     = 1'b1;
                    w_evt.err_set  = 1'b1;
                    w_evt.err_kind = srf_pkg::ST_TOO_LONG;
                end else begin
                    w_evt.push_ok = 1'b1;
                end
            end
        end
    end

    // Bytes past the length are stored as zero, so a pop needs no masking.
    always_comb begin
        w_wr_slot.mac  = i_mac;
        w_wr_slot.rssi = unsigned'(i_rssi);
        w_wr_slot.len  = w_len;
        for (int w = 0; w < srf_pkg::PAY_WORDS; w++) begin
            w_wr_slot.payload[w] = w_pay_in[w] & srf_pkg::word_mask(w_len, 2'(w));
        end
    end

    srf_stat #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_stat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (w_evt),
        .o_wr_idx   (w_wr_idx),
        .o_rd_idx   (w_rd_idx),
        .o_count    (o_fill_count),
        .o_drop     (o_drop_count),
        .o_peak     (o_high_water),
        .o_err      (w_err),
        .o_flags    (w_flags)
    );

    srf_ram #(
        .DEPTH      (FIFO_DEPTH),
        .ADDR_W     (IDX_W)
    ) u_ram (
        .i_clk      (i_clk),
        .i_wr_en    (w_evt.push_ok),
        .i_wr_addr  (w_wr_idx),
        .i_wr_data  (w_wr_slot),
        .i_rd_en    (w_evt.pop_ok),
        .i_rd_addr  (w_rd_idx),
        .o_rd_data  (w_rd_slot)
    );

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_pop_ok <= w_evt.pop_ok;
        end
    end

    // Counters and read data only move when an item is accepted, which cannot
    // happen while a result is held, so they feed the result fields directly.
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_last_error    = w_err;
    assign o_out_mac       = r_pop_ok ? w_rd_slot.mac : '0;
    assign o_out_rssi      = r_pop_ok ? signed'(w_rd_slot.rssi) : '0;
    assign o_out_len       = r_pop_ok ? w_rd_slot.len : '0;
    assign o_out_payload_0 = r_pop_ok ? w_rd_slot.payload[0] : '0;
    assign o_out_payload_1 = r_pop_ok ? w_rd_slot.payload[1] : '0;
    assign o_out_payload_2 = r_pop_ok ? w_rd_slot.payload[2] : '0;
    assign o_out_payload_3 = r_pop_ok ? w_rd_slot.payload[3] : '0;

endmodule

@@ hw/rtl/srf_chk.sv @@
// Port-level checker for the scan report FIFO, bound to the top level.
// Depends on srf_pkg and the assertion macros in scan_report_fifo_defines.svh.
`include "scan_report_fifo_defines.svh"

module srf_chk #(
    parameter int FIFO_DEPTH = srf_pkg::FIFO_DEPTH_DEF,
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [1:0]                          o_status,
    input  logic [srf_pkg::MAC_W-1:0]           o_out_mac,
    input  logic [srf_pkg::LEN_W-1:0]           o_out_len,
    input  logic [srf_pkg::WORD_W-1:0]          o_out_payload_0,
    input  logic [CNT_W-1:0]                    o_fill_count,
    input  logic [srf_pkg::DROP_W-1:0]          o_drop_count,
    input  logic [CNT_W-1:0]                    o_high_water
);

    logic                                                w_held;
    logic                                                w_failed;
    logic                                                w_drop_shown;
    logic [2+srf_pkg::MAC_W+srf_pkg::WORD_W-1:0]         w_held_view;

    assign w_held       = o_out_valid && i_out_stall;
    assign w_failed     = o_out_valid && (o_status != srf_pkg::ST_OK);
    assign w_drop_shown = o_out_valid &&
                          ((o_status == srf_pkg::ST_FULL) || (o_status == srf_pkg::ST_TOO_LONG));
    assign w_held_view  = {o_status, o_out_mac, o_out_payload_0};

    // A held result keeps its status and popped report.
    `SRF_ASSERT_NEXT(a_out_hold, w_held, o_out_valid && $stable(w_held_view), "held result changed")

    // The fill count never exceeds the depth.
    `SRF_ASSERT_NOW(a_fill_bound, 1'b1, o_fill_count <= CNT_W'(FIFO_DEPTH), "fill count above depth")

    // The high-water mark never falls outside reset.
    `SRF_ASSERT_NOW(a_peak_mono, $past(i_rst_n), o_high_water >= $past(o_high_water), "peak fell")

    // The drop count moves only together with a dropped-push result.
    `SRF_ASSERT_NOW(a_drop_cause, $past(i_rst_n) && !w_drop_shown, $stable(o_drop_count), "stray drop")

    // A failed item carries a zero report length.
    `SRF_ASSERT_NOW(a_fail_zero, w_failed, o_out_len == '0, "failed item carries report data")

endmodule

bind scan_report_fifo srf_chk #(.FIFO_DEPTH(FIFO_DEPTH)) u_srf_chk (.*);

@@ tb/sv/tb_scan_report_fifo.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the scan report FIFO: directed and random push/pop traffic with back-pressure,
// checked against a cycle-free model of the ring, its drop counter and its high-water mark.
// Depends on srf_pkg and the scan_report_fifo RTL.
module tb_scan_report_fifo;

    localparam int DEPTH          = srf_pkg::FIFO_DEPTH_DEF;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int MAC_W          = srf_pkg::MAC_W;
    localparam int RSSI_W         = srf_pkg::RSSI_W;
    localparam int LEN_IN_W       = srf_pkg::LEN_IN_W;
    localparam int LEN_W          = srf_pkg::LEN_W;
    localparam int PAY_WORDS      = srf_pkg::PAY_WORDS;
    localparam int WORD_W         = srf_pkg::WORD_W;
    localparam int DROP_W         = srf_pkg::DROP_W;
    localparam int PAY_LIMIT      = srf_pkg::PAYLOAD_LIMIT;
    localparam int RANDOM_OPS     = 1300;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 600;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                              opcode;
        logic [MAC_W-1:0]                  mac;
        logic [RSSI_W-1:0]                 rssi;
        logic [LEN_IN_W-1:0]               len;
        logic [PAY_WORDS-1:0][WORD_W-1:0]  pay;
        logic                              after_drain;
    } t_scan_op;

    typedef struct packed {
        srf_pkg::t_status                  status;
        srf_pkg::t_status                  last_err;
        logic [MAC_W-1:0]                  mac;
        logic [RSSI_W-1:0]                 rssi;
        logic [LEN_W-1:0]                  len;
        logic [PAY_WORDS-1:0][WORD_W-1:0]  pay;
        logic [CNT_W-1:0]                  fill;
        logic [DROP_W-1:0]                 drops;
        logic [CNT_W-1:0]                  peak;
    } t_report;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic                        i_operation = srf_pkg::OP_PUSH;
    logic [MAC_W-1:0]            i_mac = '0;
    logic signed [RSSI_W-1:0]    i_rssi = '0;
    logic [LEN_IN_W-1:0]         i_payload_len = '0;
    logic [WORD_W-1:0]           i_payload_0 = '0;
    logic [WORD_W-1:0]           i_payload_1 = '0;
    logic [WORD_W-1:0]           i_payload_2 = '0;
    logic [WORD_W-1:0]           i_payload_3 = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [1:0]                  o_status;
    logic [1:0]                  o_last_error;
    logic [MAC_W-1:0]            o_out_mac;
    logic signed [RSSI_W-1:0]    o_out_rssi;
    logic [LEN_W-1:0]            o_out_len;
    logic [WORD_W-1:0]           o_out_payload_0;
    logic [WORD_W-1:0]           o_out_payload_1;
    logic [WORD_W-1:0]           o_out_payload_2;
    logic [WORD_W-1:0]           o_out_payload_3;
    logic [CNT_W-1:0]            o_fill_count;
    logic [DROP_W-1:0]           o_drop_count;
    logic [CNT_W-1:0]            o_high_water;

    scan_report_fifo u_top (.*);

    always #2 i_clk = ~i_clk;

    // Ring contents and bookkeeping as the block should hold them.
    logic [MAC_W-1:0]                  ring_mac [DEPTH];
    logic [RSSI_W-1:0]                 ring_rssi [DEPTH];
    logic [LEN_W-1:0]                  ring_len [DEPTH];
    logic [PAY_WORDS-1:0][WORD_W-1:0]  ring_pay [DEPTH];
    int                                wr_ptr = 0;
    int                                rd_ptr = 0;
    int                                held = 0;
    logic [DROP_W-1:0]                 dropped = '0;
    int                                peak = 0;
    srf_pkg::t_status                  sticky = srf_pkg::ST_OK;

    t_scan_op  pending_ops [$];
    t_report   expected_reports [$];
    t_scan_op  cur = '0;
    logic      drain_next = 1'b0;
    logic      in_took = 1'b0;
    logic      hold_active = 1'b0;
    int        items_in = 0;
    int        fail_count = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        stall_mode = 0;
    int        stall_phase = 0;

    function automatic logic [WORD_W-1:0] bytes_below(input int len, input int word);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (word * 8 + b < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic t_report predict_report(input t_scan_op op);
        t_report r;
        srf_pkg::t_status drop_code;
        r = '0;
        drop_code = srf_pkg::ST_OK;
        if (op.opcode == srf_pkg::OP_PUSH) begin
            // A full ring wins over an oversized payload.
            if (held == DEPTH) begin
                drop_code = srf_pkg::ST_FULL;
            end else if (op.len > PAY_LIMIT) begin
                drop_code = srf_pkg::ST_TOO_LONG;
            end else begin
                ring_mac[wr_ptr]  = op.mac;
                ring_rssi[wr_ptr] = op.rssi;
                ring_len[wr_ptr]  = op.len[LEN_W-1:0];
                for (int w = 0; w < PAY_WORDS; w++) begin
                    ring_pay[wr_ptr][w] = op.pay[w] & bytes_below(op.len, w);
                end
                wr_ptr = (wr_ptr + 1) % DEPTH;
                held++;
            end
            if (drop_code != srf_pkg::ST_OK) begin
                if (dropped != '1) begin
                    dropped++;
                end
                sticky = drop_code;
                r.status = drop_code;
            end
        end else if (held == 0) begin
            r.status = srf_pkg::ST_EMPTY;
            sticky = srf_pkg::ST_EMPTY;
        end else begin
            r.mac  = ring_mac[rd_ptr];
            r.rssi = ring_rssi[rd_ptr];
            r.len  = ring_len[rd_ptr];
            r.pay  = ring_pay[rd_ptr];
            if (held > peak) begin
                peak = held;
            end
            rd_ptr = (rd_ptr + 1) % DEPTH;
            held--;
        end
        r.last_err = sticky;
        r.fill     = CNT_W'(held);
        r.drops    = dropped;
        r.peak     = CNT_W'(peak);
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly legal lengths, with the edges and oversized values mixed in.
    function automatic int random_len();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return PAY_LIMIT;
            2, 3:    return $urandom_range(PAY_LIMIT + 1, 255);
            default: return $urandom_range(0, PAY_LIMIT);
        endcase
    endfunction

    function automatic t_scan_op push_op(input int len);
        t_scan_op op;
        op = '0;
        op.opcode = srf_pkg::OP_PUSH;
        op.mac    = {16'($urandom), 32'($urandom)};
        op.rssi   = 8'($urandom);
        op.len    = LEN_IN_W'(len);
        for (int w = 0; w < PAY_WORDS; w++) begin
            op.pay[w] = random_word();
        end
        return op;
    endfunction

    function automatic t_scan_op pop_op();
        t_scan_op op;
        op = '0;
        op.opcode = srf_pkg::OP_POP;
        // Fields of a pop are don't-care; keep them moving anyway.
        op.mac = {16'($urandom), 32'($urandom)};
        op.len = 8'($urandom);
        return op;
    endfunction

    function automatic void add_op(input t_scan_op op);
        op.after_drain = drain_next;
        drain_next = 1'b0;
        pending_ops.push_back(op);
    endfunction

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endtask

    // Stimulus build, reset and end of run.
    initial begin
        t_scan_op op;
        int n;
        int total;
        int dir_lens [5];

        dir_lens = '{1, 8, 9, 17, 25};
        add_op(pop_op());
        op = push_op(0);
        op.mac = '0;
        op.rssi = 8'sh80;
        op.pay = '1;
        add_op(op);
        op = push_op(PAY_LIMIT);
        op.mac = '1;
        op.rssi = 8'sh7F;
        op.pay = '1;
        add_op(op);
        add_op(push_op(PAY_LIMIT + 1));
        add_op(push_op(255));
        foreach (dir_lens[k]) begin
            op = push_op(dir_lens[k]);
            op.pay = '1;
            add_op(op);
        end
        op = push_op(PAY_LIMIT);
        op.pay = '0;
        add_op(op);
        repeat (9) add_op(pop_op());
        total = pending_ops.size() + RANDOM_OPS;

        drain_next = 1'b1;
        while (pending_ops.size() < total) begin
            if ($urandom_range(0, 14) == 0) begin
                drain_next = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    n = $urandom_range(8, 40);
                    repeat (n) begin
                        if ($urandom_range(0, 99) < 55) add_op(push_op(random_len()));
                        else add_op(pop_op());
                    end
                end
                4, 5, 6, 7: begin
                    // Fill past the top, try an oversized push while full, then drain.
                    n = $urandom_range(DEPTH, DEPTH + 4);
                    repeat (n) add_op(push_op(random_len()));
                    add_op(push_op($urandom_range(PAY_LIMIT + 1, 255)));
                    n = $urandom_range(DEPTH - 2, DEPTH + 4);
                    repeat (n) add_op(pop_op());
                end
                default: begin
                    n = $urandom_range(2, 8);
                    repeat (n) add_op(pop_op());
                    n = $urandom_range(1, 4);
                    repeat (n) add_op(push_op($urandom_range(PAY_LIMIT + 1, 255)));
                end
            endcase
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_in_valid || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_scan_report_fifo OK");
        end else begin
            $display("tb_scan_report_fifo NOT OK");
        end
        $finish;
    end

    // Sender: bursts of items separated by random gaps, ignored while the receiver is held off.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (gap_left > 0 && !hold_active) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].after_drain && expected_reports.size() != 0)) begin
                cur = pending_ops.pop_front();
                i_operation   <= cur.opcode;
                i_mac         <= cur.mac;
                i_rssi        <= cur.rssi;
                i_payload_len <= cur.len;
                i_payload_0   <= cur.pay[0];
                i_payload_1   <= cur.pay[1];
                i_payload_2   <= cur.pay[2];
                i_payload_3   <= cur.pay[3];
                i_in_valid    <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 60);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: a stall pattern whose character is redrawn at random each time stall_phase runs out.
    always @(negedge i_clk) begin
        logic pat;
        if (stall_phase == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_phase = 128;
        end
        stall_phase--;
        case (stall_mode)
            0:       pat = 1'b0;
            1:       pat = ($urandom_range(0, 99) < 30);
            2:       pat = ($urandom_range(0, 99) < 75);
            default: pat = ((stall_phase % 5) < 2);
        endcase
        i_out_stall <= hold_active || pat;
    end

    // One long hold-off on the result side so the block backs up into its input.
    initial begin
        while (items_in < HOLD_AFTER) @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_report want;
        in_took <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_reports.push_back(predict_report(cur));
            items_in++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                fail_count++;
                $error("result item arrived with no item outstanding");
            end else begin
                want = expected_reports.pop_front();
                compare_field("status", 64'(want.status), 64'(o_status));
                compare_field("last_error", 64'(want.last_err), 64'(o_last_error));
                compare_field("out_mac", 64'(want.mac), 64'(o_out_mac));
                compare_field("out_rssi", 64'(want.rssi), 64'($unsigned(o_out_rssi)));
                compare_field("out_len", 64'(want.len), 64'(o_out_len));
                compare_field("out_payload_0", want.pay[0], o_out_payload_0);
                compare_field("out_payload_1", want.pay[1], o_out_payload_1);
                compare_field("out_payload_2", want.pay[2], o_out_payload_2);
                compare_field("out_payload_3", want.pay[3], o_out_payload_3);
                compare_field("fill_count", 64'(want.fill), 64'(o_fill_count));
                compare_field("drop_count", 64'(want.drops), 64'(o_drop_count));
                compare_field("high_water", 64'(want.peak), 64'(o_high_water));
            end
        end
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb_scan_report_fifo NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/srf_pkg.sv
hw/rtl/srf_ram.sv
hw/rtl/srf_stat.sv
hw/rtl/scan_report_fifo.sv
hw/rtl/srf_chk.sv
tb/sv/tb_scan_report_fifo.sv
